// ===== hw/rtl/tone_code_to_note_and_bend_defines.svh =====
`ifndef TONE_CODE_TO_NOTE_AND_BEND_DEFINES_SVH
`define TONE_CODE_TO_NOTE_AND_BEND_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every edge out of reset
`define TCNB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcnb assertion failed");
// cons must hold in the cycle after ante
`define TCNB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcnb assertion failed");
`else
`define TCNB_ASSERT(label, clk, rst_n, prop)
`define TCNB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/tcnb_pkg.sv =====
package tcnb_pkg;

    localparam int CODE_W    = 11;
    localparam int NOTE_W    = 7;
    localparam int BEND_W    = 12;
    localparam int TABLE_LEN = 72;
    localparam int IDX_W     = 7;
    localparam int STEP_W    = 7;   // table steps and gaps stay below 128
    localparam int FRAC_W    = 12;
    localparam int HALF_SEMI = 2048;

    localparam int BASE_NOTE_DEF = 36;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_STAGES    = 3;
    localparam int DIV_DIGITS    = FRAC_W / DIV_STAGES;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [CODE_W-1:0] PERIOD_TABLE [TABLE_LEN] = '{
        11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
        11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
        11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
        11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
        11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
        11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
        11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
        11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
        11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
        11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
        11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
        11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
    };

    typedef enum logic [1:0] {
        KIND_FLAT  = 2'd0,   // below first entry or exact hit: bend 0
        KIND_FRAC  = 2'd1,   // between entries: needs the divide
        KIND_ABOVE = 2'd2    // past the last entry: saturate
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  idx;
        logic [STEP_W-1:0] gap;
        logic [STEP_W-1:0] step;
    } job_t;

endpackage

// ===== hw/rtl/tcnb_front.sv =====
module tcnb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tcnb_pkg::CODE_W-1:0]   in_code,
    output logic                          job_valid,
    input  logic                          job_ready,
    output tcnb_pkg::job_t                job
);

    logic                        valid_reg, valid_next;
    logic [tcnb_pkg::CODE_W-1:0] code_reg, code_next;

    logic                         above;
    logic [tcnb_pkg::IDX_W-1:0]   idx;
    logic [tcnb_pkg::IDX_W-1:0]   prev_idx;
    logic [tcnb_pkg::CODE_W-1:0]  entry;
    logic [tcnb_pkg::CODE_W-1:0]  prev;
    logic [tcnb_pkg::CODE_W-1:0]  gap_full;
    logic [tcnb_pkg::CODE_W-1:0]  step_full;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            code_next  = in_code;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        code_reg <= code_next;
    end

    // first entry at or above the code
    always_comb begin
        above = 1'b1;
        idx   = tcnb_pkg::IDX_W'(tcnb_pkg::TABLE_LEN - 1);
        for (int i = tcnb_pkg::TABLE_LEN - 1; i >= 0; i--) begin
            if (tcnb_pkg::PERIOD_TABLE[i] >= code_reg) begin
                above = 1'b0;
                idx   = tcnb_pkg::IDX_W'(i);
            end
        end
    end

    assign prev_idx  = (idx == '0) ? '0 : idx - 1'b1;
    assign entry     = tcnb_pkg::PERIOD_TABLE[idx];
    assign prev      = tcnb_pkg::PERIOD_TABLE[prev_idx];
    assign gap_full  = entry - code_reg;
    assign step_full = entry - prev;

    always_comb begin
        job.idx  = idx;
        job.gap  = gap_full[tcnb_pkg::STEP_W-1:0];
        job.step = step_full[tcnb_pkg::STEP_W-1:0];
        if (above) begin
            job.kind = tcnb_pkg::KIND_ABOVE;
        end else if (idx == '0 || entry == code_reg) begin
            job.kind = tcnb_pkg::KIND_FLAT;
        end else begin
            job.kind = tcnb_pkg::KIND_FRAC;
        end
    end

endmodule

// ===== hw/rtl/tcnb_queue.sv =====
`include "tone_code_to_note_and_bend_defines.svh"

module tcnb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  tcnb_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tcnb_pkg::job_t  pop_job
);

    localparam int DEPTH = tcnb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcnb_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `TCNB_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `TCNB_ASSERT_NEXT(a_fill_tracks, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hw/rtl/tcnb_back.sv =====
`include "tone_code_to_note_and_bend_defines.svh"

module tcnb_back #(
    parameter int BASE_NOTE = tcnb_pkg::BASE_NOTE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  tcnb_pkg::job_t                job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcnb_pkg::NOTE_W-1:0]   out_note,
    output logic [tcnb_pkg::BEND_W-1:0]   out_bend,
    output logic                          out_above
);

    localparam int STAGES = tcnb_pkg::DIV_STAGES;
    localparam int DIGITS = tcnb_pkg::DIV_DIGITS;
    localparam int STEP_W = tcnb_pkg::STEP_W;
    localparam int FRAC_W = tcnb_pkg::FRAC_W;
    localparam logic [tcnb_pkg::NOTE_W-1:0] BASE = tcnb_pkg::NOTE_W'(BASE_NOTE);

    logic                 en;
    logic                 stg_valid_reg [STAGES];
    tcnb_pkg::job_t       stg_job_reg   [STAGES];
    logic [STEP_W-1:0]    stg_rem_reg   [STAGES];
    logic [FRAC_W-1:0]    stg_quo_reg   [STAGES];

    logic                        out_valid_reg, out_valid_next;
    logic [tcnb_pkg::NOTE_W-1:0] note_reg, note_next;
    logic [tcnb_pkg::BEND_W-1:0] bend_reg, bend_next;
    logic                        above_reg, above_next;

    tcnb_pkg::job_t       fin_job;
    logic [FRAC_W-1:0]    fin_quo;

    assign en        = !out_valid_reg || out_ready;
    assign job_ready = en;

    // restoring divide of gap * 4096 by step, four quotient bits per stage
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 valid_in;
        tcnb_pkg::job_t       job_in;
        logic [STEP_W-1:0]    rem_in;
        logic [FRAC_W-1:0]    quo_in;
        logic [STEP_W-1:0]    rem_next;
        logic [FRAC_W-1:0]    quo_next;

        if (k == 0) begin : g_head
            assign valid_in = job_valid;
            assign job_in   = job;
            assign rem_in   = job.gap;
            assign quo_in   = '0;
        end else begin : g_body
            assign valid_in = stg_valid_reg[k-1];
            assign job_in   = stg_job_reg[k-1];
            assign rem_in   = stg_rem_reg[k-1];
            assign quo_in   = stg_quo_reg[k-1];
        end

        always_comb begin
            logic [STEP_W:0] trial;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int d = 0; d < DIGITS; d++) begin
                trial = {rem_next, 1'b0};
                if (trial >= {1'b0, job_in.step}) begin
                    trial    = trial - {1'b0, job_in.step};
                    quo_next = {quo_next[FRAC_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_next[FRAC_W-2:0], 1'b0};
                end
                rem_next = trial[STEP_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[k] <= 1'b0;
            end else if (en) begin
                stg_valid_reg[k] <= valid_in;
            end
            if (en) begin
                stg_job_reg[k] <= job_in;
                stg_rem_reg[k] <= rem_next;
                stg_quo_reg[k] <= quo_next;
            end
        end
    end

    assign fin_job = stg_job_reg[STAGES-1];
    assign fin_quo = stg_quo_reg[STAGES-1];

    always_comb begin
        out_valid_next = stg_valid_reg[STAGES-1];
        note_next      = BASE + fin_job.idx;
        bend_next      = '0;
        above_next     = 1'b0;
        case (fin_job.kind)
            tcnb_pkg::KIND_ABOVE: begin
                above_next = 1'b1;
            end
            tcnb_pkg::KIND_FRAC: begin
                // 4096 - frac and -frac share the same low 12 bits
                bend_next = tcnb_pkg::BEND_W'(FRAC_W'(0) - fin_quo);
                if (fin_quo > FRAC_W'(tcnb_pkg::HALF_SEMI)) begin
                    note_next = BASE + fin_job.idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= out_valid_next;
        end
        if (en) begin
            note_reg  <= note_next;
            bend_reg  <= bend_next;
            above_reg <= above_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_note  = note_reg;
    assign out_bend  = bend_reg;
    assign out_above = above_reg;

    `TCNB_ASSERT(a_frac_nonzero, aclk, aresetn, !(stg_valid_reg[STAGES-1] && fin_job.kind == tcnb_pkg::KIND_FRAC) || fin_quo != '0)
    `TCNB_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, out_valid_reg && !out_ready, $stable(stg_valid_reg[STAGES-1]) && $stable(note_reg))

endmodule

// ===== hw/rtl/tone_code_to_note_and_bend.sv =====
// channel  | dir | fields (low bit first)
// s_       | in  | tdata: period_code[10:0]
// m_       | out | tdata: note_number[6:0], bend_amount[18:7]; tuser: above_table
//
// Sustains one request per cycle while m_tready is high. Results pass the search
// register, the queue, the three-stage restoring divider (four quotient bits each)
// and the output register. A four-entry queue sits between search and divider.
// Output stall freezes the divider; the search side keeps filling the queue.
// Reset is synchronous on aresetn and clears all valid state.
module tone_code_to_note_and_bend #(
    parameter int BASE_NOTE = tcnb_pkg::BASE_NOTE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcnb_pkg::S_TDATA_W-1:0]  s_tdata,   // period_code[10:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcnb_pkg::M_TDATA_W-1:0]  m_tdata,   // note_number, bend_amount
    output logic [0:0]                      m_tuser    // above_table
);

    logic                         f_valid, f_ready;
    tcnb_pkg::job_t               f_job;
    logic                         q_valid, q_ready;
    tcnb_pkg::job_t               q_job;
    logic [tcnb_pkg::NOTE_W-1:0]  note;
    logic [tcnb_pkg::BEND_W-1:0]  bend;
    logic                         above;

    tcnb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tdata[tcnb_pkg::CODE_W-1:0]),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    tcnb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    tcnb_back #(
        .BASE_NOTE (BASE_NOTE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_note  (note),
        .out_bend  (bend),
        .out_above (above)
    );

    assign m_tdata = {{(tcnb_pkg::M_TDATA_W - tcnb_pkg::BEND_W - tcnb_pkg::NOTE_W){1'b0}},
                      bend, note};
    assign m_tuser = above;

endmodule
